### rtl/pedg_pkg.sv
package pedg_pkg;

    localparam int ROWS_DEFAULT = 480;

    localparam int PIX_W      = 8;
    localparam int ROW_IN_W   = 9;
    localparam int LEVEL_W    = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int COLOUR_W   = 24;

    // grey weights in q14, with rounding constant
    localparam int GREY_SUM_W = 22;
    localparam int GREY_SHIFT = 14;
    localparam logic [13:0] W_RED   = 14'd4899;
    localparam logic [13:0] W_GREEN = 14'd9617;
    localparam logic [13:0] W_BLUE  = 14'd1868;
    localparam logic [GREY_SUM_W-1:0] GREY_ROUND = GREY_SUM_W'(8192);

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
    localparam logic [PIX_W-1:0] PIX_MIN = 8'd0;

    localparam logic [LEVEL_W-1:0] LEVEL_MID = 7'd50;

    // contrast: x*level/50 by reciprocal, exact for products below 2^15
    localparam int CPROD_W = PIX_W + LEVEL_W;
    localparam int CQ_W    = 10;
    localparam int CRECIP_SHIFT = 21;
    localparam logic [15:0] CRECIP = 16'd41944;
    localparam logic [5:0] CDIV      = 6'd50;
    localparam logic [5:0] CDIV_HALF = 6'd25;

    typedef enum logic [2:0] {
        MODE_PASS     = 3'd0,
        MODE_BRIGHT   = 3'd1,
        MODE_CONTRAST = 3'd2,
        MODE_INVERT   = 3'd3,
        MODE_THRESH   = 3'd4,
        MODE_DUOTONE  = 3'd5
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE       = 3'd0,
        CFG_BRIGHTNESS = 3'd1,
        CFG_CONTRAST   = 3'd2,
        CFG_THRESHOLD  = 3'd3,
        CFG_DARK       = 3'd4,
        CFG_LIGHT      = 3'd5,
        CFG_DARK_EN    = 3'd6,
        CFG_LIGHT_EN   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        t_mode                    mode;
        logic [LEVEL_W-1:0]       brightness;
        logic [LEVEL_W-1:0]       contrast;
        logic [PIX_W-1:0]         threshold;
        logic [2*COLOUR_W-1:0]    dark;
        logic [2*COLOUR_W-1:0]    light;
        logic                     dark_en;
        logic                     light_en;
    } t_cfg;

    typedef logic [2:0][PIX_W-1:0] t_pixel;

endpackage

### rtl/pedg_front.sv
module pedg_front import pedg_pkg::*; #(
    parameter int ROWS = ROWS_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  t_cfg                        i_cfg,
    input  t_pixel                      i_pixel,
    input  logic [ROW_IN_W-1:0]         i_row,
    output logic                        o_valid,
    output logic [GREY_SUM_W-1:0]       o_grey_sum,
    output logic [$clog2(ROWS)-1:0]     o_row,
    output logic [$clog2(ROWS)-1:0]     o_row_inv,
    output t_pixel                      o_simple,
    output logic [2:0][CPROD_W-1:0]     o_cprod
);

    localparam int DEN_W = $clog2(ROWS);
    localparam int RW    = (DEN_W > ROW_IN_W) ? DEN_W : ROW_IN_W;
    localparam logic [RW-1:0]    DEN_RW = RW'(ROWS - 1);
    localparam logic [DEN_W-1:0] DEN_V  = DEN_W'(ROWS - 1);

    logic                      r_valid;
    logic [GREY_SUM_W-1:0]     r_grey_sum, n_grey_sum;
    logic [DEN_W-1:0]          r_row, n_row;
    logic [DEN_W-1:0]          r_row_inv, n_row_inv;
    t_pixel                    r_simple, n_simple;
    logic [2:0][CPROD_W-1:0]   r_cprod, n_cprod;

    always_comb begin
        logic [RW-1:0]    row_ext;
        logic signed [9:0] bsum;
        row_ext    = RW'(i_row);
        n_grey_sum = GREY_SUM_W'(i_pixel[2]) * GREY_SUM_W'(W_RED)
                   + GREY_SUM_W'(i_pixel[1]) * GREY_SUM_W'(W_GREEN)
                   + GREY_SUM_W'(i_pixel[0]) * GREY_SUM_W'(W_BLUE)
                   + GREY_ROUND;
        if (row_ext > DEN_RW) begin
            n_row = DEN_V;
        end else begin
            n_row = row_ext[DEN_W-1:0];
        end
        n_row_inv = DEN_V - n_row;
        for (int k = 0; k < 3; k++) begin
            n_cprod[k] = CPROD_W'(i_pixel[k]) * CPROD_W'(i_cfg.contrast);
            bsum = $signed({2'b00, i_pixel[k]}) + $signed({3'b000, i_cfg.brightness})
                 - $signed({3'b000, LEVEL_MID});
            case (i_cfg.mode)
                MODE_BRIGHT: begin
                    if (bsum < 0) begin
                        n_simple[k] = PIX_MIN;
                    end else if (bsum > 10'sd255) begin
                        n_simple[k] = PIX_MAX;
                    end else begin
                        n_simple[k] = bsum[7:0];
                    end
                end
                MODE_INVERT: n_simple[k] = PIX_MAX - i_pixel[k];
                default:     n_simple[k] = i_pixel[k];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_grey_sum <= n_grey_sum;
            r_row      <= n_row;
            r_row_inv  <= n_row_inv;
            r_simple   <= n_simple;
            r_cprod    <= n_cprod;
        end
    end

    assign o_valid    = r_valid;
    assign o_grey_sum = r_grey_sum;
    assign o_row      = r_row;
    assign o_row_inv  = r_row_inv;
    assign o_simple   = r_simple;
    assign o_cprod    = r_cprod;

endmodule

### rtl/pedg_blend.sv
module pedg_blend import pedg_pkg::*; #(
    parameter int ROWS = ROWS_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  t_cfg                              i_cfg,
    input  logic [GREY_SUM_W-1:0]             i_grey_sum,
    input  logic [$clog2(ROWS)-1:0]           i_row,
    input  logic [$clog2(ROWS)-1:0]           i_row_inv,
    input  t_pixel                            i_simple,
    input  logic [2:0][CPROD_W-1:0]           i_cprod,
    output logic                              o_valid,
    output logic                              o_bin,
    output logic                              o_use_blend,
    output logic [2:0][$clog2(ROWS)+7:0]      o_num,
    output t_pixel                            o_simple,
    output logic [2:0][CQ_W-1:0]              o_cq,
    output logic [2:0][CPROD_W-1:0]           o_cprod
);

    localparam int DEN_W = $clog2(ROWS);
    localparam int NUM_W = DEN_W + PIX_W;
    localparam int CP_W  = CPROD_W + 16;

    logic                      r_valid;
    logic                      r_bin, n_bin;
    logic                      r_use_blend, n_use_blend;
    logic [2:0][NUM_W-1:0]     r_num, n_num;
    t_pixel                    r_simple;
    logic [2:0][CQ_W-1:0]      r_cq, n_cq;
    logic [2:0][CPROD_W-1:0]   r_cprod;

    always_comb begin
        logic [2*COLOUR_W-1:0] pair;
        logic [CP_W-1:0]       cp;
        n_bin       = (i_grey_sum[GREY_SUM_W-1:GREY_SHIFT] > i_cfg.threshold);
        n_use_blend = n_bin ? i_cfg.light_en : i_cfg.dark_en;
        pair        = n_bin ? i_cfg.light : i_cfg.dark;
        for (int k = 0; k < 3; k++) begin
            // start colour weighted by rows left, end colour by row
            n_num[k] = NUM_W'(pair[8*k +: 8]) * NUM_W'(i_row_inv)
                     + NUM_W'(pair[COLOUR_W + 8*k +: 8]) * NUM_W'(i_row);
            cp       = CP_W'(i_cprod[k]) * CP_W'(CRECIP);
            n_cq[k]  = cp[CRECIP_SHIFT +: CQ_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bin       <= n_bin;
            r_use_blend <= n_use_blend;
            r_num       <= n_num;
            r_simple    <= i_simple;
            r_cq        <= n_cq;
            r_cprod     <= i_cprod;
        end
    end

    assign o_valid     = r_valid;
    assign o_bin       = r_bin;
    assign o_use_blend = r_use_blend;
    assign o_num       = r_num;
    assign o_simple    = r_simple;
    assign o_cq        = r_cq;
    assign o_cprod     = r_cprod;

endmodule

### rtl/pedg_div.sv
module pedg_div import pedg_pkg::*; #(
    parameter int ROWS = ROWS_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  t_cfg                              i_cfg,
    input  logic                              i_bin,
    input  logic                              i_use_blend,
    input  logic [2:0][$clog2(ROWS)+7:0]      i_num,
    input  t_pixel                            i_simple,
    input  logic [2:0][CQ_W-1:0]              i_cq,
    input  logic [2:0][CPROD_W-1:0]           i_cprod,
    output logic                              o_valid,
    output logic                              o_sel_blend,
    output logic                              o_single,
    output logic [2:0][$clog2(ROWS)+7:0]      o_num,
    output t_pixel                            o_q0,
    output t_pixel                            o_alt
);

    localparam int DEN_W = $clog2(ROWS);
    localparam int NUM_W = DEN_W + PIX_W;
    localparam int PW    = 2 * NUM_W + 1;
    // floor(2^NUM_W / den): quotient estimate is low by at most one
    localparam logic [NUM_W:0] RECIP = (NUM_W + 1)'((64'd1 << NUM_W) / (ROWS - 1));

    logic                    r_valid;
    logic                    r_sel_blend, n_sel_blend;
    logic                    r_single, n_single;
    logic [2:0][NUM_W-1:0]   r_num;
    t_pixel                  r_q0, n_q0;
    t_pixel                  r_alt, n_alt;

    always_comb begin
        logic [PW-1:0]      prod;
        logic [CPROD_W-1:0] crem_full;
        logic [5:0]         crem;
        logic               rnd_up;
        logic [CQ_W:0]      cq_rnd;
        logic [PIX_W-1:0]   contrast_px;
        logic [PIX_W-1:0]   bin_px;
        bin_px      = i_bin ? PIX_MAX : PIX_MIN;
        n_sel_blend = (i_cfg.mode == MODE_DUOTONE) && i_use_blend;
        n_single    = (i_cfg.mode == MODE_THRESH);
        for (int k = 0; k < 3; k++) begin
            prod     = PW'(i_num[k]) * PW'(RECIP);
            n_q0[k]  = prod[NUM_W +: PIX_W];

            // round half to even, then saturate
            crem_full   = i_cprod[k] - CPROD_W'(i_cq[k]) * CPROD_W'(CDIV);
            crem        = crem_full[5:0];
            rnd_up      = (crem > CDIV_HALF) || ((crem == CDIV_HALF) && i_cq[k][0]);
            cq_rnd      = (CQ_W + 1)'(i_cq[k]) + (CQ_W + 1)'(rnd_up);
            contrast_px = (cq_rnd > (CQ_W + 1)'(PIX_MAX)) ? PIX_MAX : cq_rnd[PIX_W-1:0];

            case (i_cfg.mode)
                MODE_CONTRAST: n_alt[k] = contrast_px;
                MODE_THRESH:   n_alt[k] = bin_px;
                MODE_DUOTONE:  n_alt[k] = bin_px;
                default:       n_alt[k] = i_simple[k];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sel_blend <= n_sel_blend;
            r_single    <= n_single;
            r_num       <= i_num;
            r_q0        <= n_q0;
            r_alt       <= n_alt;
        end
    end

    assign o_valid     = r_valid;
    assign o_sel_blend = r_sel_blend;
    assign o_single    = r_single;
    assign o_num       = r_num;
    assign o_q0        = r_q0;
    assign o_alt       = r_alt;

endmodule

### rtl/pixel_effect_duotone_gradient_unit.sv
// Per-pixel effect unit: one BGR pixel plus its image row in, one pixel out.
// Input channel: i_valid / o_ready with i_blue_in, i_green_in, i_red_in and
// i_row_index. Output channel: o_valid / i_ready with o_blue_out,
// o_green_out, o_red_out and o_single_channel (set in threshold mode).
// Effect registers are written through i_cfg_wr_en / i_cfg_index /
// i_cfg_data, one register per cycle; the user must write them only while
// no pixel is in flight, as the block itself does not enforce it.
// Throughput is one pixel per clock while i_ready is high. The four stages
// are: grey sum, contrast products, row clamp and simple effects; threshold
// and gradient products with the contrast quotient estimate; gradient
// division by reciprocal and contrast rounding; quotient correction and
// final select into the output register. The gradient division by ROWS-1
// is the longest path: one multiply by the reciprocal in stage three and a
// multiply, subtract, compare and add in stage four.
// Reset empties the pipeline and loads the default register values.
// When the receiver holds i_ready low the result stays on the outputs, the
// stages behind it keep filling any bubbles, and o_ready drops only once all
// four stages hold a pixel.
module pixel_effect_duotone_gradient_unit import pedg_pkg::*; #(
    parameter int ROWS = ROWS_DEFAULT
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [PIX_W-1:0]        i_blue_in,
    input  logic [PIX_W-1:0]        i_green_in,
    input  logic [PIX_W-1:0]        i_red_in,
    input  logic [ROW_IN_W-1:0]     i_row_index,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [PIX_W-1:0]        o_blue_out,
    output logic [PIX_W-1:0]        o_green_out,
    output logic [PIX_W-1:0]        o_red_out,
    output logic                    o_single_channel
);

    localparam int DEN_W = $clog2(ROWS);
    localparam int NUM_W = DEN_W + PIX_W;
    localparam logic [NUM_W-1:0] DEN_NUM = NUM_W'(ROWS - 1);

    t_cfg r_cfg;

    logic en1, en2, en3, en4;

    logic                      v1, v2, v3;
    logic [GREY_SUM_W-1:0]     s1_grey_sum;
    logic [DEN_W-1:0]          s1_row, s1_row_inv;
    t_pixel                    s1_simple;
    logic [2:0][CPROD_W-1:0]   s1_cprod;

    logic                      s2_bin, s2_use_blend;
    logic [2:0][NUM_W-1:0]     s2_num;
    t_pixel                    s2_simple;
    logic [2:0][CQ_W-1:0]      s2_cq;
    logic [2:0][CPROD_W-1:0]   s2_cprod;

    logic                      s3_sel_blend, s3_single;
    logic [2:0][NUM_W-1:0]     s3_num;
    t_pixel                    s3_q0, s3_alt;

    logic                      r_valid;
    logic                      r_single, n_single;
    t_pixel                    r_pixel, n_pixel;
    t_pixel                    pixel_in;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode       <= MODE_PASS;
            r_cfg.brightness <= LEVEL_MID;
            r_cfg.contrast   <= LEVEL_MID;
            r_cfg.threshold  <= 8'd127;
            r_cfg.dark       <= '0;
            r_cfg.light      <= '1;
            r_cfg.dark_en    <= 1'b0;
            r_cfg.light_en   <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MODE:       r_cfg.mode       <= t_mode'(i_cfg_data[2:0]);
                CFG_BRIGHTNESS: r_cfg.brightness <= i_cfg_data[LEVEL_W-1:0];
                CFG_CONTRAST:   r_cfg.contrast   <= i_cfg_data[LEVEL_W-1:0];
                CFG_THRESHOLD:  r_cfg.threshold  <= i_cfg_data[PIX_W-1:0];
                CFG_DARK:       r_cfg.dark       <= i_cfg_data[2*COLOUR_W-1:0];
                CFG_LIGHT:      r_cfg.light      <= i_cfg_data[2*COLOUR_W-1:0];
                CFG_DARK_EN:    r_cfg.dark_en    <= i_cfg_data[0];
                CFG_LIGHT_EN:   r_cfg.light_en   <= i_cfg_data[0];
                default:        r_cfg.mode       <= r_cfg.mode;
            endcase
        end
    end

    // a stage advances when it is empty or the one after it advances
    assign en4     = !r_valid || i_ready;
    assign en3     = !v3 || en4;
    assign en2     = !v2 || en3;
    assign en1     = !v1 || en2;
    assign o_ready = en1;

    assign pixel_in = {i_red_in, i_green_in, i_blue_in};

    pedg_front #(.ROWS(ROWS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en1),
        .i_valid    (i_valid),
        .i_cfg      (r_cfg),
        .i_pixel    (pixel_in),
        .i_row      (i_row_index),
        .o_valid    (v1),
        .o_grey_sum (s1_grey_sum),
        .o_row      (s1_row),
        .o_row_inv  (s1_row_inv),
        .o_simple   (s1_simple),
        .o_cprod    (s1_cprod)
    );

    pedg_blend #(.ROWS(ROWS)) u_blend (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en2),
        .i_valid     (v1),
        .i_cfg       (r_cfg),
        .i_grey_sum  (s1_grey_sum),
        .i_row       (s1_row),
        .i_row_inv   (s1_row_inv),
        .i_simple    (s1_simple),
        .i_cprod     (s1_cprod),
        .o_valid     (v2),
        .o_bin       (s2_bin),
        .o_use_blend (s2_use_blend),
        .o_num       (s2_num),
        .o_simple    (s2_simple),
        .o_cq        (s2_cq),
        .o_cprod     (s2_cprod)
    );

    pedg_div #(.ROWS(ROWS)) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en3),
        .i_valid     (v2),
        .i_cfg       (r_cfg),
        .i_bin       (s2_bin),
        .i_use_blend (s2_use_blend),
        .i_num       (s2_num),
        .i_simple    (s2_simple),
        .i_cq        (s2_cq),
        .i_cprod     (s2_cprod),
        .o_valid     (v3),
        .o_sel_blend (s3_sel_blend),
        .o_single    (s3_single),
        .o_num       (s3_num),
        .o_q0        (s3_q0),
        .o_alt       (s3_alt)
    );

    // gradient quotient correction and final select
    always_comb begin
        logic [NUM_W-1:0] rem;
        n_single = s3_single;
        for (int k = 0; k < 3; k++) begin
            rem = s3_num[k] - NUM_W'(s3_q0[k]) * DEN_NUM;
            if (!s3_sel_blend) begin
                n_pixel[k] = s3_alt[k];
            end else if (rem >= DEN_NUM) begin
                n_pixel[k] = s3_q0[k] + 8'd1;
            end else begin
                n_pixel[k] = s3_q0[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en4) begin
            r_valid <= v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_pixel  <= n_pixel;
            r_single <= n_single;
        end
    end

    assign o_valid          = r_valid;
    assign o_blue_out       = r_pixel[0];
    assign o_green_out      = r_pixel[1];
    assign o_red_out        = r_pixel[2];
    assign o_single_channel = r_single;

`ifndef NO_ASSERTIONS
    a_single_mode : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_single_channel == (r_cfg.mode == MODE_THRESH)))
        else $error("single_channel disagrees with effect mode");

    a_thresh_grey : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_single_channel) |->
            (o_blue_out == o_green_out) && (o_green_out == o_red_out)
            && ((o_blue_out == PIX_MIN) || (o_blue_out == PIX_MAX)))
        else $error("threshold result is not binary grey");

    a_full_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready && v1 && v2 && v3))
        else $error("input stalled while the pipeline has room");

    a_div_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (v3 && s3_sel_blend) |->
            ((s3_num[0] - NUM_W'(s3_q0[0]) * DEN_NUM) < (DEN_NUM << 1)))
        else $error("gradient quotient estimate off by more than one");
`endif

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import pedg_pkg::*;

    localparam int ROWS        = ROWS_DEFAULT;
    localparam int LAST_ROW    = ROWS - 1;
    localparam int MAX_GAP     = 8;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE      = 8;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASES      = 24;
    localparam int PHASE_ITEMS = 70;

    // modes without a name in the package, both behave as pass-through
    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       single;
    } t_pixel_result;

    class pixel_scoreboard;
        logic [2:0]  mode;
        logic [6:0]  brightness;
        logic [6:0]  contrast;
        logic [7:0]  threshold;
        logic [47:0] dark;
        logic [47:0] light;
        logic        dark_en;
        logic        light_en;
        t_pixel_result expected_pixels[$];
        int errors;
        int results_seen;

        function new();
            mode         = MODE_PASS;
            brightness   = 7'd50;
            contrast     = 7'd50;
            threshold    = 8'd127;
            dark         = '0;
            light        = '1;
            dark_en      = 1'b0;
            light_en     = 1'b0;
            errors       = 0;
            results_seen = 0;
        endfunction

        function void mirror_reg(t_cfg_idx idx, logic [47:0] data);
            case (idx)
                CFG_MODE:       mode       = data[2:0];
                CFG_BRIGHTNESS: brightness = data[6:0];
                CFG_CONTRAST:   contrast   = data[6:0];
                CFG_THRESHOLD:  threshold  = data[7:0];
                CFG_DARK:       dark       = data;
                CFG_LIGHT:      light      = data;
                CFG_DARK_EN:    dark_en    = data[0];
                CFG_LIGHT_EN:   light_en   = data[0];
                default: ;
            endcase
        endfunction

        function logic [7:0] offset_channel(logic [7:0] x);
            int v;
            v = int'(x) + int'(brightness) - 50;
            if (v < 0) return 8'd0;
            if (v > 255) return 8'd255;
            return 8'(v);
        endfunction

        function logic [7:0] gain_channel(logic [7:0] x);
            int unsigned num;
            int unsigned q;
            int unsigned rem;
            num = int'(x) * int'(contrast);
            q   = num / 50;
            rem = num % 50;
            // round half to even
            if (rem > 25 || (rem == 25 && q[0])) q++;
            if (q > 255) return 8'd255;
            return 8'(q);
        endfunction

        function logic [7:0] binary_of(logic [7:0] b, logic [7:0] g, logic [7:0] r);
            int unsigned grey;
            grey = (4899 * int'(r) + 9617 * int'(g) + 1868 * int'(b) + 8192) >> 14;
            return (grey > int'(threshold)) ? 8'd255 : 8'd0;
        endfunction

        function t_pixel_result gradient(logic [47:0] pair, int unsigned row);
            t_pixel_result px;
            int unsigned c1[3];
            int unsigned c2[3];
            int unsigned ch[3];
            for (int k = 0; k < 3; k++) begin
                c1[k] = pair[8*k +: 8];
                c2[k] = pair[24 + 8*k +: 8];
                ch[k] = (c1[k] * (LAST_ROW - row) + c2[k] * row) / LAST_ROW;
            end
            px.blue   = 8'(ch[0]);
            px.green  = 8'(ch[1]);
            px.red    = 8'(ch[2]);
            px.single = 1'b0;
            return px;
        endfunction

        function t_pixel_result effect_of(logic [7:0] b, logic [7:0] g, logic [7:0] r,
                                          logic [8:0] row_in);
            t_pixel_result px;
            int unsigned row;
            logic [7:0] bin;
            row = (int'(row_in) > LAST_ROW) ? LAST_ROW : int'(row_in);
            px.single = 1'b0;
            case (mode)
                MODE_BRIGHT: begin
                    px.blue  = offset_channel(b);
                    px.green = offset_channel(g);
                    px.red   = offset_channel(r);
                end
                MODE_CONTRAST: begin
                    px.blue  = gain_channel(b);
                    px.green = gain_channel(g);
                    px.red   = gain_channel(r);
                end
                MODE_INVERT: begin
                    px.blue  = 8'd255 - b;
                    px.green = 8'd255 - g;
                    px.red   = 8'd255 - r;
                end
                MODE_THRESH: begin
                    bin = binary_of(b, g, r);
                    px.blue   = bin;
                    px.green  = bin;
                    px.red    = bin;
                    px.single = 1'b1;
                end
                MODE_DUOTONE: begin
                    bin = binary_of(b, g, r);
                    if (bin == 8'd0 && dark_en) begin
                        px = gradient(dark, row);
                    end else if (bin != 8'd0 && light_en) begin
                        px = gradient(light, row);
                    end else begin
                        px.blue  = bin;
                        px.green = bin;
                        px.red   = bin;
                    end
                end
                default: begin
                    px.blue  = b;
                    px.green = g;
                    px.red   = r;
                end
            endcase
            return px;
        endfunction

        function void note_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r,
                                 logic [8:0] row);
            expected_pixels.insert(expected_pixels.size(), effect_of(b, g, r, row));
        endfunction

        task report(string what, logic [31:0] want, logic [31:0] got);
            errors++;
            $display("mismatch: %s at result %0d, expected %0h, got %0h",
                     what, results_seen, want, got);
        endtask

        task check_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic s);
            t_pixel_result want;
            results_seen++;
            if (expected_pixels.size() == 0) begin
                report("result with no pixel outstanding", 32'd0, 32'({b, g, r}));
                return;
            end
            want = expected_pixels.pop_front();
            if (b !== want.blue)   report("blue_out", 32'(want.blue), 32'(b));
            if (g !== want.green)  report("green_out", 32'(want.green), 32'(g));
            if (r !== want.red)    report("red_out", 32'(want.red), 32'(r));
            if (s !== want.single) report("single_channel", 32'(want.single), 32'(s));
        endtask

        function int outstanding();
            return expected_pixels.size();
        endfunction

        task final_check();
            if (expected_pixels.size() != 0)
                report("pixels never returned", 32'(expected_pixels.size()), 32'd0);
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_ready;
    logic [PIX_W-1:0]      i_blue_in;
    logic [PIX_W-1:0]      i_green_in;
    logic [PIX_W-1:0]      i_red_in;
    logic [ROW_IN_W-1:0]   i_row_index;
    logic                  o_valid;
    logic                  i_ready;
    logic [PIX_W-1:0]      o_blue_out;
    logic [PIX_W-1:0]      o_green_out;
    logic [PIX_W-1:0]      o_red_out;
    logic                  o_single_channel;

    pixel_scoreboard sb;
    bit no_idle      = 1'b0;
    bit hold_request = 1'b0;
    int stall_cycles = 0;

    pixel_effect_duotone_gradient_unit #(
        .ROWS(ROWS)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_blue_in        (i_blue_in),
        .i_green_in       (i_green_in),
        .i_red_in         (i_red_in),
        .i_row_index      (i_row_index),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_blue_out       (o_blue_out),
        .o_green_out      (o_green_out),
        .o_red_out        (o_red_out),
        .o_single_channel (o_single_channel)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ends the run when no transaction happens on either side for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic cfg_write(input t_cfg_idx idx, input logic [47:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.mirror_reg(idx, data);
    endtask

    task automatic set_mode(input logic [2:0] mode);
        cfg_write(CFG_MODE, 48'(mode));
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic load_settings(input logic [2:0] mode, input logic [6:0] bright,
                                 input logic [6:0] gain, input logic [7:0] thr,
                                 input logic [47:0] dark, input logic [47:0] light,
                                 input logic dark_en, input logic light_en);
        cfg_write(CFG_MODE, 48'(mode));
        cfg_write(CFG_BRIGHTNESS, 48'(bright));
        cfg_write(CFG_CONTRAST, 48'(gain));
        cfg_write(CFG_THRESHOLD, 48'(thr));
        cfg_write(CFG_DARK, dark);
        cfg_write(CFG_LIGHT, light);
        cfg_write(CFG_DARK_EN, 48'(dark_en));
        cfg_write(CFG_LIGHT_EN, 48'(light_en));
        i_cfg_wr_en <= 1'b0;
    endtask

    // called at a clock edge; returns at the edge where the transaction happens
    task automatic send_pixel(input logic [7:0] b, input logic [7:0] g,
                              input logic [7:0] r, input logic [8:0] row);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_blue_in   <= b;
        i_green_in  <= g;
        i_red_in    <= r;
        i_row_index <= row;
        do @(posedge i_clk); while (!o_ready);
        sb.note_pixel(b, g, r, row);
    endtask

    // stop offering and let the pipeline empty before touching registers
    task automatic finish_phase();
        i_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [6:0] pick_level();
        case ($urandom_range(0, 5))
            0:       return 7'd0;
            1:       return 7'd100;
            default: return 7'($urandom_range(0, 100));
        endcase
    endfunction

    // result side
    initial begin
        int hold;
        i_ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                hold = LONG_HOLD;
            end else begin
                hold = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (hold > 0) begin
                i_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            sb.check_pixel(o_blue_out, o_green_out, o_red_out, o_single_channel);
        end
    end

    initial begin
        logic [2:0]  mode;
        logic [7:0]  thr;
        logic [1:0]  enables;
        logic [7:0]  b, g, r;
        logic [8:0]  row;
        logic [47:0] dark, light;
        int          v;

        sb = new();
        i_rst_n     <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_index <= CFG_MODE;
        i_cfg_data  <= '0;
        i_valid     <= 1'b0;
        i_blue_in   <= '0;
        i_green_in  <= '0;
        i_red_in    <= '0;
        i_row_index <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // register defaults straight out of reset
        send_pixel(8'd0, 8'd0, 8'd0, 9'd0);
        send_pixel(8'd255, 8'd255, 8'd255, 9'd479);
        finish_phase();
        set_mode(MODE_BRIGHT);
        send_pixel(8'd0, 8'd128, 8'd255, 9'd1);
        finish_phase();
        set_mode(MODE_CONTRAST);
        send_pixel(8'd1, 8'd254, 8'd255, 9'd2);
        finish_phase();
        set_mode(MODE_THRESH);
        send_pixel(8'd127, 8'd127, 8'd127, 9'd3);
        send_pixel(8'd128, 8'd128, 8'd128, 9'd4);
        finish_phase();
        set_mode(MODE_DUOTONE);
        send_pixel(8'd127, 8'd127, 8'd127, 9'd10);
        send_pixel(8'd128, 8'd128, 8'd128, 9'd20);
        finish_phase();
        // light gradient with its default colours
        cfg_write(CFG_LIGHT_EN, 48'd1);
        i_cfg_wr_en <= 1'b0;
        send_pixel(8'd200, 8'd200, 8'd200, 9'd100);
        finish_phase();

        // saturation at both ends of the brightness and contrast ranges
        load_settings(MODE_BRIGHT, 7'd0, 7'd50, 8'd127, '0, '1, 1'b0, 1'b0);
        send_pixel(8'd0, 8'd49, 8'd50, 9'd0);
        finish_phase();
        load_settings(MODE_BRIGHT, 7'd100, 7'd50, 8'd127, '0, '1, 1'b0, 1'b0);
        send_pixel(8'd205, 8'd206, 8'd100, 9'd0);
        finish_phase();
        load_settings(MODE_CONTRAST, 7'd50, 7'd100, 8'd127, '0, '1, 1'b0, 1'b0);
        send_pixel(8'd127, 8'd128, 8'd0, 9'd0);
        finish_phase();
        load_settings(MODE_CONTRAST, 7'd50, 7'd0, 8'd127, '0, '1, 1'b0, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 9'd0);
        finish_phase();
        // half gain: exact halves round to the even neighbour
        load_settings(MODE_CONTRAST, 7'd50, 7'd25, 8'd127, '0, '1, 1'b0, 1'b0);
        send_pixel(8'd1, 8'd3, 8'd5, 9'd0);
        finish_phase();
        load_settings(MODE_INVERT, 7'd50, 7'd50, 8'd127, '0, '1, 1'b0, 1'b0);
        send_pixel(8'd0, 8'd255, 8'h5A, 9'd0);
        finish_phase();
        // strict compare at the threshold extremes
        load_settings(MODE_THRESH, 7'd50, 7'd50, 8'd0, '0, '1, 1'b0, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd0, 9'd0);
        send_pixel(8'd1, 8'd1, 8'd1, 9'd0);
        finish_phase();
        load_settings(MODE_THRESH, 7'd50, 7'd50, 8'd255, '0, '1, 1'b0, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 9'd0);
        finish_phase();
        // gradients at the first, middle, last and beyond-last rows
        load_settings(MODE_DUOTONE, 7'd50, 7'd50, 8'd127, 48'hFF8040_0010FF,
                      48'h204060_C0E0FF, 1'b1, 1'b1);
        send_pixel(8'd10, 8'd20, 8'd30, 9'd0);
        send_pixel(8'd10, 8'd20, 8'd30, 9'd479);
        send_pixel(8'd10, 8'd20, 8'd30, 9'd511);
        send_pixel(8'd0, 8'd0, 8'd0, 9'd240);
        send_pixel(8'd250, 8'd240, 8'd230, 9'd0);
        send_pixel(8'd250, 8'd240, 8'd230, 9'd479);
        send_pixel(8'd255, 8'd255, 8'd255, 9'd300);
        finish_phase();
        set_mode(MODE_SPARE_A);
        send_pixel(8'd12, 8'd34, 8'd56, 9'd480);
        finish_phase();
        set_mode(MODE_SPARE_B);
        send_pixel(8'd200, 8'd100, 8'd50, 9'd7);
        finish_phase();

        for (int p = 0; p < PHASES; p++) begin
            mode = 3'(p % 8);
            case ($urandom_range(0, 3))
                0:       thr = 8'd0;
                1:       thr = 8'd255;
                default: thr = 8'($urandom_range(0, 255));
            endcase
            dark  = {16'($urandom), 32'($urandom)};
            light = {16'($urandom), 32'($urandom)};
            // duotone phases step through the enable combinations with at least one enable set
            enables = (mode == MODE_DUOTONE) ? 2'((p >> 3) + 1) : 2'($urandom_range(0, 3));
            load_settings(mode, pick_level(), pick_level(), thr, dark, light,
                          enables[1], enables[0]);
            no_idle      = ($urandom_range(0, 3) == 0);
            hold_request = (p == 3 || p == 17);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 9) < 2) begin
                    // grey of an equal-channel pixel is the channel itself
                    v = int'(thr) + int'($urandom_range(0, 2)) - 1;
                    if (v < 0) v = 0;
                    if (v > 255) v = 255;
                    b = 8'(v);
                    g = 8'(v);
                    r = 8'(v);
                end else begin
                    b = 8'($urandom);
                    g = 8'($urandom);
                    r = 8'($urandom);
                end
                case ($urandom_range(0, 15))
                    0:       row = 9'd0;
                    1:       row = 9'(LAST_ROW);
                    2:       row = 9'($urandom_range(LAST_ROW + 1, 511));
                    default: row = 9'($urandom_range(0, LAST_ROW));
                endcase
                send_pixel(b, g, r, row);
            end
            finish_phase();
        end
        no_idle = 1'b0;

        sb.final_check();
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
